[rtl/env_sensor_compensation_defines.svh]
`ifndef ENV_SENSOR_COMPENSATION_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_DEFINES_SVH

// Checked property, quiet while reset is asserted
`define ECS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset
`define ECS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ecs_pkg.sv]
package ecs_pkg;

    localparam int NSTG      = 46;
    localparam int DIV_FIRST = 11;
    localparam int DIV_LAST  = 42;

    localparam logic [2:0] REG_CAL_TEMP     = 3'd0;
    localparam logic [2:0] REG_CAL_PRESS_LO = 3'd1;
    localparam logic [2:0] REG_CAL_PRESS_HI = 3'd2;
    localparam logic [2:0] REG_CAL_MIXED    = 3'd3;
    localparam logic [2:0] REG_CAL_HUM      = 3'd4;

    localparam logic signed [31:0] PRESS_MAX = 32'sd16777215;
    localparam logic signed [31:0] HUM_MAX   = 32'sd419430400;

    typedef struct packed {
        logic signed [31:0] at;
        logic signed [31:0] dd;
        logic signed [31:0] tf;
        logic signed [15:0] tc;
        logic signed [31:0] pv1;
        logic signed [31:0] pa;
        logic signed [31:0] pb;
        logic signed [31:0] pc;
        logic signed [31:0] pd;
        logic signed [31:0] hv;
        logic signed [31:0] ha;
        logic signed [31:0] hb;
        logic signed [31:0] hc;
        logic [31:0]        num;
        logic [31:0]        dv;
        logic [31:0]        rem;
        logic [31:0]        quo;
        logic               dbl;
        logic               err;
        logic [23:0]        press;
        logic [16:0]        hum;
        logic [19:0]        adc_p;
        logic [15:0]        adc_h;
    } pipe_t;

endpackage

[rtl/env_sensor_compensation.sv]
// Pipeline: 46 register stages; a result is offered on the master side once it
// reaches the last stage, and transfers when m_tready is high.
// Throughput: one item per cycle; the whole pipeline, including the 32-step
// radix-2 pressure divider, advances together whenever the output stage is free.
// Reset: rst_n clears all valid bits and calibration registers asynchronously;
// the block is ready to accept items once reset is released, as no stage then holds a valid item.
module env_sensor_compensation
    import ecs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // temp_centi[15:0], press_pa[39:16], hum_q10[56:40], zero
    output logic        m_tuser,   // press_error
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

`include "env_sensor_compensation_defines.svh"

    logic [47:0] cal_temp_reg;
    logic [63:0] cal_press_lo_reg;
    logic [63:0] cal_press_hi_reg;
    logic [47:0] cal_mixed_reg;
    logic [31:0] cal_hum_reg;

    logic              wr_en;
    logic [2:0]        reg_idx;
    logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [31:0] h1, h2, h3, h4, h5, h6;

    pipe_t             s_reg [NSTG];
    pipe_t             s_next [NSTG];
    pipe_t             in_item;
    logic [NSTG-1:0]   valid_reg;
    logic              en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg     <= '0;
            cal_press_lo_reg <= '0;
            cal_press_hi_reg <= '0;
            cal_mixed_reg    <= '0;
            cal_hum_reg      <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_CAL_TEMP:     cal_temp_reg     <= pwdata[47:0];
                REG_CAL_PRESS_LO: cal_press_lo_reg <= pwdata;
                REG_CAL_PRESS_HI: cal_press_hi_reg <= pwdata;
                REG_CAL_MIXED:    cal_mixed_reg    <= pwdata[47:0];
                REG_CAL_HUM:      cal_hum_reg      <= pwdata[31:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CAL_TEMP:     prdata = {16'd0, cal_temp_reg};
            REG_CAL_PRESS_LO: prdata = cal_press_lo_reg;
            REG_CAL_PRESS_HI: prdata = cal_press_hi_reg;
            REG_CAL_MIXED:    prdata = {16'd0, cal_mixed_reg};
            REG_CAL_HUM:      prdata = {32'd0, cal_hum_reg};
            default:          prdata = '0;
        endcase
    end

    // calibration words, widened to 32 bits
    always_comb
    begin
        t1 = $signed({16'd0, cal_temp_reg[15:0]});
        t2 = $signed({{16{cal_temp_reg[31]}}, cal_temp_reg[31:16]});
        t3 = $signed({{16{cal_temp_reg[47]}}, cal_temp_reg[47:32]});
        p1 = $signed({16'd0, cal_press_lo_reg[15:0]});
        p2 = $signed({{16{cal_press_lo_reg[31]}}, cal_press_lo_reg[31:16]});
        p3 = $signed({{16{cal_press_lo_reg[47]}}, cal_press_lo_reg[47:32]});
        p4 = $signed({{16{cal_press_lo_reg[63]}}, cal_press_lo_reg[63:48]});
        p5 = $signed({{16{cal_press_hi_reg[15]}}, cal_press_hi_reg[15:0]});
        p6 = $signed({{16{cal_press_hi_reg[31]}}, cal_press_hi_reg[31:16]});
        p7 = $signed({{16{cal_press_hi_reg[47]}}, cal_press_hi_reg[47:32]});
        p8 = $signed({{16{cal_press_hi_reg[63]}}, cal_press_hi_reg[63:48]});
        p9 = $signed({{16{cal_mixed_reg[15]}}, cal_mixed_reg[15:0]});
        h1 = $signed({24'd0, cal_mixed_reg[23:16]});
        h2 = $signed({{16{cal_mixed_reg[39]}}, cal_mixed_reg[39:24]});
        h3 = $signed({24'd0, cal_mixed_reg[47:40]});
        h4 = $signed({{20{cal_hum_reg[11]}}, cal_hum_reg[11:0]});
        h5 = $signed({{20{cal_hum_reg[23]}}, cal_hum_reg[23:12]});
        h6 = $signed({24'd0, cal_hum_reg[31:24]});
    end

    function automatic pipe_t stage_fn(input int k, input pipe_t x);
        pipe_t              y;
        logic [32:0]        r33;
        logic signed [31:0] s;
        logic [31:0]        u;
        y = x;
        if (k >= DIV_FIRST && k <= DIV_LAST)
        begin
            // one restoring divide step: shift in next dividend bit
            r33   = {x.rem, x.num[31]};
            y.num = {x.num[30:0], 1'b0};
            if (r33 >= {1'b0, x.dv})
            begin
                r33   = r33 - {1'b0, x.dv};
                y.quo = {x.quo[30:0], 1'b1};
            end
            else
            begin
                y.quo = {x.quo[30:0], 1'b0};
            end
            y.rem = r33[31:0];
        end
        case (k)
            0:
            begin
                y.at = (x.at >>> 3) - (t1 <<< 1);
                y.dd = (x.at >>> 4) - t1;
            end
            1:
            begin
                y.at = x.at * t2;
                y.dd = x.dd * x.dd;
            end
            2:
            begin
                y.at = x.at >>> 11;
                y.dd = (x.dd >>> 12) * t3;
            end
            3:  y.tf = x.at + (x.dd >>> 14);
            4:
            begin
                y.at  = x.tf * 32'sd5;
                y.pv1 = (x.tf >>> 1) - 32'sd64000;
                y.hv  = x.tf - 32'sd76800;
            end
            5:
            begin
                s = (x.at + 32'sd128) >>> 8;
                if (s < -32'sd32768)
                    y.tc = 16'sh8000;
                else if (s > 32'sd32767)
                    y.tc = 16'sh7fff;
                else
                    y.tc = s[15:0];
                y.pa = (x.pv1 >>> 2) * (x.pv1 >>> 2);
                y.pb = x.pv1 * p5;
                y.pc = p2 * x.pv1;
                y.ha = h5 * x.hv;
                y.hb = x.hv * h6;
                y.hc = x.hv * h3;
            end
            6:
            begin
                y.pd = (x.pa >>> 11) * p6;
                y.pa = p3 * (x.pa >>> 13);
                y.ha = (($signed({16'd0, x.adc_h}) <<< 14) - (h4 <<< 20)) - x.ha;
                y.hb = x.hb >>> 10;
                y.hc = (x.hc >>> 11) + 32'sd32768;
            end
            7:
            begin
                y.pd = ((x.pd + (x.pb <<< 1)) >>> 2) + (p4 <<< 16);
                y.pa = ((x.pa >>> 3) + (x.pc >>> 1)) >>> 18;
                y.ha = (x.ha + 32'sd16384) >>> 15;
                y.hb = x.hb * x.hc;
            end
            8:
            begin
                y.pa = (32'sd32768 + x.pa) * p1;
                y.pd = (32'sd1048576 - $signed({12'd0, x.adc_p})) - (x.pd >>> 12);
                y.hb = (x.hb >>> 10) + 32'sd2097152;
            end
            9:
            begin
                y.pa = x.pa >>> 15;
                y.pd = x.pd * 32'sd3125;
                y.hb = x.hb * h2;
            end
            10:
            begin
                y.err = (x.pa == 32'sd0);
                y.dv  = x.pa;
                y.rem = '0;
                y.quo = '0;
                // large numerator: divide first, double afterwards
                y.dbl = x.pd[31];
                y.num = x.pd[31] ? x.pd : {x.pd[30:0], 1'b0};
                y.hb  = (x.hb + 32'sd8192) >>> 14;
            end
            11: y.ha = x.ha * x.hb;
            12: y.hb = (x.ha >>> 15) * (x.ha >>> 15);
            13: y.hb = (x.hb >>> 7) * h1;
            14:
            begin
                s = x.ha - (x.hb >>> 4);
                if (s < 32'sd0)
                    s = 32'sd0;
                if (s > HUM_MAX)
                    s = HUM_MAX;
                y.hum = s[28:12];
            end
            43:
            begin
                u    = x.dbl ? {x.quo[30:0], 1'b0} : x.quo;
                y.pc = u;
                // square wraps at 32 bits before the logical shift
                y.pb = $signed({3'd0, u[31:3]} * {3'd0, u[31:3]});
                y.pb = $signed({13'd0, y.pb[31:13]});
            end
            44:
            begin
                y.pb = p9 * x.pb;
                y.pd = $signed({2'd0, x.pc[31:2]}) * p8;
            end
            45:
            begin
                s = x.pc + ((((x.pb >>> 12) + (x.pd >>> 13)) + p7) >>> 4);
                if (s < 32'sd0)
                    s = 32'sd0;
                if (s > PRESS_MAX)
                    s = PRESS_MAX;
                y.press = x.err ? 24'd0 : s[23:0];
            end
            default: ;
        endcase
        return y;
    endfunction

    always_comb
    begin
        in_item       = '0;
        in_item.at    = $signed({12'd0, s_tdata[19:0]});
        in_item.adc_p = s_tdata[39:20];
        in_item.adc_h = s_tdata[55:40];
    end

    always_comb
    begin
        for (int k = 0; k < NSTG; k++)
        begin
            if (k == 0)
                s_next[k] = stage_fn(k, in_item);
            else
                s_next[k] = stage_fn(k, s_reg[k-1]);
        end
    end

    // advance everything while the output stage is empty or being taken
    assign en       = !valid_reg[NSTG-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[NSTG-2:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s_reg <= s_next;
    end

    assign m_tvalid = valid_reg[NSTG-1];
    assign m_tdata  = {7'd0, s_reg[NSTG-1].hum, s_reg[NSTG-1].press, s_reg[NSTG-1].tc};
    assign m_tuser  = s_reg[NSTG-1].err;

    `ECS_ASSERT(err_zero_press, m_tvalid && m_tuser |-> m_tdata[39:16] == 24'd0,
        "pressure not zero on divide error")
    `ECS_ASSERT(hum_range, m_tvalid |-> m_tdata[56:40] <= 17'd102400,
        "humidity above full scale")
    `ECS_ASSERT(enter_valid, s_tvalid && s_tready |=> valid_reg[0],
        "accepted item lost at entry")
    `ECS_ASSERT_ALWAYS(stall_hold, rst_n && !en |=> !rst_n || $stable(valid_reg),
        "pipeline moved while stalled")

endmodule
